[src/lcg_cycle_measure_top_defines.svh]
// Assertion macros for the cycle measurement block.
// Both expect clk in scope at the place of use; LCM_ASSERT also expects rst_n.
`ifndef LCG_CYCLE_MEASURE_TOP_DEFINES_SVH
`define LCG_CYCLE_MEASURE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset
`define LCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define LCM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCM_ASSERT(lbl, prop, msg)
`define LCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[src/lcm_pkg.sv]
package lcm_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRED,
        ST_MUL,
        ST_RED,
        ST_CHECK,
        ST_OUT
    } lcm_state_t;

    // Search phases of the tortoise-and-hare walk
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_MEET,
        PH_TAIL,
        PH_CYCLE
    } lcm_phase_t;

endpackage

[src/lcg_cycle_measure_top.sv]
// Counts the distinct values of x(k+1) = (multiplier*x(k) + increment) mod modulus started
// at seed, using the tortoise-and-hare search (meet, tail length, cycle length), and returns
// tail plus cycle length; a zero modulus returns 0 with bad_modulus set. All arithmetic
// goes through one multiplier and one remainder unit that retires one dividend bit per
// cycle; each generator step runs a multiply and a full reduction, and the increment is
// reduced once per query. A query steps the tortoise and hare to their meeting point,
// then walks the tail and the cycle. in_ready is high only while the block is idle; the
// result sits in an output register, so the next query can be taken before the last
// result is read.
`include "lcg_cycle_measure_top_defines.svh"

module lcg_cycle_measure_top
    import lcm_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] multiplier,
    input  logic [VALUE_BITS-1:0] increment,
    input  logic [VALUE_BITS-1:0] modulus,
    input  logic [VALUE_BITS-1:0] seed,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS:0]   distinct_count,
    output logic                  bad_modulus
);

    localparam int W     = VALUE_BITS;
    localparam int DIV_W = 2 * W + 1;
    localparam int CNT_W = $clog2(DIV_W + 1);

    lcm_state_t        state_reg, state_next;
    lcm_phase_t        phase_reg, phase_next;
    logic [1:0]        sub_reg, sub_next;
    logic              sel_h_reg, sel_h_next;
    logic              bad_reg, bad_next;
    logic [W-1:0]      z_reg, z_next;
    logic [W-1:0]      mod_reg, mod_next;
    logic [W-1:0]      seed_reg, seed_next;
    logic [W-1:0]      cmod_reg, cmod_next;
    logic [W-1:0]      t_reg, t_next;
    logic [W-1:0]      h_reg, h_next;
    logic [W:0]        mu_reg, mu_next;
    logic [W:0]        lam_reg, lam_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [W:0]        out_count_reg, out_count_next;
    logic              out_bad_reg, out_bad_next;

    logic [W-1:0]      operand;
    logic [2*W-1:0]    product;
    logic [W:0]        shifted;
    logic [W:0]        diff;
    logic [W-1:0]      rem_step;
    logic              red_last;

    // Shared multiplier: one generator product per step
    assign operand = sel_h_reg ? h_reg : t_reg;
    assign product = z_reg * operand;

    // Shared remainder unit: bring in one dividend bit, subtract the modulus if it fits
    assign shifted  = {rem_reg, div_reg[DIV_W-1]};
    assign diff     = shifted - {1'b0, mod_reg};
    assign rem_step = (shifted >= {1'b0, mod_reg}) ? diff[W-1:0] : shifted[W-1:0];
    assign red_last = (cnt_reg == CNT_W'(DIV_W - 1));

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign distinct_count = out_count_reg;
    assign bad_modulus    = out_bad_reg;

    // Sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sub_next       = sub_reg;
        sel_h_next     = sel_h_reg;
        bad_next       = bad_reg;
        z_next         = z_reg;
        mod_next       = mod_reg;
        seed_next      = seed_reg;
        cmod_next      = cmod_reg;
        t_next         = t_reg;
        h_next         = h_reg;
        mu_next        = mu_reg;
        lam_next       = lam_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_bad_next   = out_bad_reg;

        // Drop the result once the transfer completes
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    z_next    = multiplier;
                    mod_next  = modulus;
                    seed_next = seed;
                    div_next  = {{(W + 1){1'b0}}, increment};
                    rem_next  = '0;
                    cnt_next  = '0;
                    if (modulus == '0)
                    begin
                        bad_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = ST_CRED;
                    end
                end
            end

            ST_CRED:
            begin
                // Reduce the increment once, then start the meeting search
                div_next = {div_reg[DIV_W-2:0], 1'b0};
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (red_last)
                begin
                    cmod_next  = rem_step;
                    t_next     = seed_reg;
                    h_next     = seed_reg;
                    phase_next = PH_MEET;
                    sub_next   = 2'd0;
                    state_next = ST_CHECK;
                end
            end

            ST_MUL:
            begin
                div_next   = {1'b0, product} + {{(W + 1){1'b0}}, cmod_reg};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_RED;
            end

            ST_RED:
            begin
                div_next = {div_reg[DIV_W-2:0], 1'b0};
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (red_last)
                begin
                    if (sel_h_reg)
                    begin
                        h_next = rem_step;
                    end
                    else
                    begin
                        t_next = rem_step;
                    end
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                case (phase_reg)
                    PH_MEET:
                    begin
                        // Tortoise one step, hare two steps, then compare
                        case (sub_reg)
                            2'd0:
                            begin
                                sel_h_next = 1'b0;
                                sub_next   = 2'd1;
                                state_next = ST_MUL;
                            end
                            2'd1:
                            begin
                                sel_h_next = 1'b1;
                                sub_next   = 2'd2;
                                state_next = ST_MUL;
                            end
                            2'd2:
                            begin
                                sel_h_next = 1'b1;
                                sub_next   = 2'd3;
                                state_next = ST_MUL;
                            end
                            default:
                            begin
                                if (h_reg == t_reg)
                                begin
                                    h_next     = seed_reg;
                                    mu_next    = '0;
                                    phase_next = PH_TAIL;
                                end
                                sub_next = 2'd0;
                            end
                        endcase
                    end

                    PH_TAIL:
                    begin
                        // Walk both from seed and meeting point until they agree
                        if (sub_reg == 2'd0)
                        begin
                            if (h_reg == t_reg)
                            begin
                                phase_next = PH_CYCLE;
                            end
                            else
                            begin
                                sel_h_next = 1'b1;
                                sub_next   = 2'd1;
                                state_next = ST_MUL;
                            end
                        end
                        else
                        begin
                            mu_next    = mu_reg + 1'b1;
                            sel_h_next = 1'b0;
                            sub_next   = 2'd0;
                            state_next = ST_MUL;
                        end
                    end

                    PH_CYCLE:
                    begin
                        // Advance the hare around the cycle once
                        if (sub_reg == 2'd0)
                        begin
                            lam_next   = {{W{1'b0}}, 1'b1};
                            sel_h_next = 1'b1;
                            sub_next   = 2'd1;
                            state_next = ST_MUL;
                        end
                        else if (h_reg == t_reg)
                        begin
                            phase_next = PH_IDLE;
                            sub_next   = 2'd0;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            lam_next   = lam_reg + 1'b1;
                            sel_h_next = 1'b1;
                            state_next = ST_MUL;
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_bad_next   = bad_reg;
                    out_count_next = bad_reg ? '0 : (mu_reg + lam_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            sub_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
            t_reg         <= '0;
            h_reg         <= '0;
            mu_reg        <= '0;
            lam_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
            t_reg         <= t_next;
            h_reg         <= h_next;
            mu_reg        <= mu_next;
            lam_reg       <= lam_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sel_h_reg     <= sel_h_next;
        bad_reg       <= bad_next;
        z_reg         <= z_next;
        mod_reg       <= mod_next;
        seed_reg      <= seed_next;
        cmod_reg      <= cmod_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        out_count_reg <= out_count_next;
        out_bad_reg   <= out_bad_next;
    end

    // Checks
    `LCM_ASSERT(a_rem_below_mod, (state_reg == ST_RED) |-> (rem_reg < mod_reg), "remainder not below modulus")
    `LCM_ASSERT(a_bad_gives_zero, (out_valid_reg && out_bad_reg) |-> (out_count_reg == '0), "bad modulus with nonzero count")
    `LCM_ASSERT(a_good_nonzero, (out_valid_reg && !out_bad_reg) |-> (out_count_reg != '0), "good query with zero count")
    `LCM_ASSERT_ALWAYS(a_idle_phase, (state_reg == ST_IDLE) |-> (phase_reg == PH_IDLE), "idle with search phase active")

endmodule
